>>> rtl/core/iir_direct_form_one_filter_defines.svh
// ----------------------------------------------------------------------------
// IIR direct form I filter - assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef IIR_DIRECT_FORM_ONE_FILTER_DEFINES_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_DEFINES_SVH

`ifndef SYNTH
// property must hold at every edge outside reset
`define IIRDF1_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("iirdf1 assertion failed");
// condition must never be true outside reset
`define IIRDF1_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("iirdf1 forbidden condition");
`else
`define IIRDF1_ASSERT(lbl, clk, rst_n, prop)
`define IIRDF1_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> rtl/core/iirdf1_pkg.sv
// ----------------------------------------------------------------------------
// IIR direct form I filter - package
// Widths, register indexes, controller states and command/status types.
// ----------------------------------------------------------------------------
package iirdf1_pkg;

	localparam int FILTER_ORDER = 3;
	localparam int SAMPLE_WIDTH = 16;
	localparam int COEF_WIDTH   = 32;
	localparam int COEF_FRAC    = 28;

	localparam int NUM_REGS      = 7;
	localparam int REG_IDX_W     = 3;
	localparam int REG_FF_COEF_0 = 0;
	localparam int REG_FB_COEF_1 = 4;
	localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << COEF_FRAC;

	localparam int NUM_TAPS = 2 * FILTER_ORDER + 1;
	localparam int TAP_W    = $clog2(NUM_TAPS);
	localparam int PROD_W   = COEF_WIDTH + SAMPLE_WIDTH;
	localparam int ACC_W    = PROD_W + $clog2(NUM_TAPS);
	localparam int Y_W      = ACC_W - COEF_FRAC;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic             start;
		logic             issue;
		logic [TAP_W-1:0] tap;
		logic             load_out;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

>>> rtl/core/iirdf1_ctrl.sv
// ----------------------------------------------------------------------------
// IIR direct form I filter - controller
// Sequences one word: accept, one tap per cycle, drain, write result.
// ----------------------------------------------------------------------------
module iirdf1_ctrl
	import iirdf1_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output cmd_t    cmd,
	input  status_t status
);

	localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(NUM_TAPS - 1);

	state_t           state_q, state_d;
	logic [TAP_W-1:0] tap_q, tap_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q   <= '0;
		end else begin
			state_q <= state_d;
			tap_q   <= tap_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		tap_d        = tap_q;
		in_ready     = 1'b0;
		cmd.start    = 1'b0;
		cmd.issue    = 1'b0;
		cmd.tap      = tap_q;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					tap_d     = '0;
					state_d   = ST_MAC;
				end
			end
			ST_MAC: begin
				cmd.issue = 1'b1;
				if (tap_q == LAST_TAP) begin
					state_d = ST_DRAIN;
				end else begin
					tap_d = tap_q + TAP_W'(1);
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/core/iirdf1_dp.sv
// ----------------------------------------------------------------------------
// IIR direct form I filter - datapath
// Coefficient registers, sample histories, shared multiply-accumulate,
// rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module iirdf1_dp
	import iirdf1_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [REG_IDX_W-1:0]           cfg_index,
	input  logic [COEF_WIDTH-1:0]          cfg_data,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic                           block_start,
	input  cmd_t                           cmd,
	output status_t                        status,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output logic                           clipped
);

	localparam logic signed [Y_W-1:0] Y_MAX = Y_W'((2 ** (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [Y_W-1:0] Y_MIN = -Y_MAX - Y_W'(1);
	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC - 1);

	logic [COEF_WIDTH-1:0]          coef_q [NUM_REGS];
	logic signed [SAMPLE_WIDTH-1:0] pin_q  [FILTER_ORDER];
	logic signed [SAMPLE_WIDTH-1:0] pout_q [FILTER_ORDER];
	logic signed [SAMPLE_WIDTH-1:0] x_q;

	logic signed [SAMPLE_WIDTH-1:0] operand;
	logic signed [COEF_WIDTH-1:0]   coef_sel;
	logic                           sub;

	logic signed [PROD_W-1:0] prod_s1;
	logic                     sub_s1;
	logic                     prod_v_s1;
	logic signed [ACC_W-1:0]  acc_q;

	logic signed [ACC_W-1:0]        rnd;
	logic signed [Y_W-1:0]          y_full;
	logic signed [SAMPLE_WIDTH-1:0] y_sat;
	logic                           clip;

	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
	logic                           clipped_q;

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_REGS; r++) begin
				coef_q[r] <= (r == REG_FF_COEF_0) ? COEF_ONE : '0;
			end
		end else begin
			for (int r = 0; r < NUM_REGS; r++) begin
				if (cfg_we && (cfg_index == REG_IDX_W'(r))) begin
					coef_q[r] <= cfg_data;
				end
			end
		end
	end

	// histories: clear on block start, advance on result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < FILTER_ORDER; k++) begin
				pin_q[k]  <= '0;
				pout_q[k] <= '0;
			end
		end else if (cmd.start && block_start) begin
			for (int k = 0; k < FILTER_ORDER; k++) begin
				pin_q[k]  <= '0;
				pout_q[k] <= '0;
			end
		end else if (cmd.load_out) begin
			for (int k = FILTER_ORDER - 1; k > 0; k--) begin
				pin_q[k]  <= pin_q[k-1];
				pout_q[k] <= pout_q[k-1];
			end
			pin_q[0]  <= x_q;
			pout_q[0] <= y_sat;
		end
	end

	// tap select
	always_comb begin
		operand  = x_q;
		coef_sel = $signed(coef_q[REG_FF_COEF_0]);
		sub      = 1'b0;
		for (int k = 1; k <= FILTER_ORDER; k++) begin
			if (cmd.tap == TAP_W'(k)) begin
				operand  = pin_q[k-1];
				coef_sel = $signed(coef_q[REG_FF_COEF_0 + k]);
				sub      = 1'b0;
			end
			if (cmd.tap == TAP_W'(FILTER_ORDER + k)) begin
				operand  = pout_q[k-1];
				coef_sel = $signed(coef_q[REG_FB_COEF_1 + k - 1]);
				sub      = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q <= sample_in;
		end
		prod_s1 <= coef_sel * operand;
		sub_s1  <= sub;
		if (cmd.start) begin
			acc_q <= '0;
		end else if (prod_v_s1) begin
			if (sub_s1) begin
				acc_q <= acc_q - ACC_W'(prod_s1);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_s1 <= 1'b0;
		end else begin
			prod_v_s1 <= cmd.issue;
		end
	end

	// round half up, drop fraction, saturate
	always_comb begin
		rnd    = acc_q + RND_HALF;
		y_full = rnd[ACC_W-1:COEF_FRAC];
		clip   = 1'b0;
		y_sat  = y_full[SAMPLE_WIDTH-1:0];
		if (y_full > Y_MAX) begin
			y_sat = Y_MAX[SAMPLE_WIDTH-1:0];
			clip  = 1'b1;
		end else if (y_full < Y_MIN) begin
			y_sat = Y_MIN[SAMPLE_WIDTH-1:0];
			clip  = 1'b1;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			sample_out_q <= y_sat;
			clipped_q    <= clip;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign sample_out      = sample_out_q;
	assign clipped         = clipped_q;

endmodule

>>> rtl/core/iir_direct_form_one_filter.sv
// ----------------------------------------------------------------------------
// IIR direct form I filter - top level
// Third-order fixed-point IIR filter, Q1.15 samples, Q4.28 coefficients.
//
//   channel  direction  handshake             word
//   in       sink       in_valid/in_ready     sample_in, block_start
//   out      source     out_valid/out_ready   sample_out, clipped
//   cfg      sink       cfg_we                cfg_index, cfg_data
//
// Each word passes through accept, one tap per cycle through the shared
// multiplier, one drain, one result write; the single multiply-accumulate
// unit bounds throughput, and one word is in work.
// The next word is accepted while a finished result waits in the output
// register; a stalled output holds the result write until the register frees.
// Reset clears histories and the controller, and loads default coefficients.
// ----------------------------------------------------------------------------
`include "iir_direct_form_one_filter_defines.svh"

module iir_direct_form_one_filter
	import iirdf1_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [REG_IDX_W-1:0]           cfg_index,
	input  logic [COEF_WIDTH-1:0]          cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic                           block_start,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output logic                           clipped
);

	localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX = SAMPLE_WIDTH'((2 ** (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN = -OUT_MAX - SAMPLE_WIDTH'(1);

	cmd_t    cmd;
	status_t status;

	iirdf1_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.status   (status)
	);

	iirdf1_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample_in   (sample_in),
		.block_start (block_start),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sample_out  (sample_out),
		.clipped     (clipped)
	);

	`IIRDF1_ASSERT(a_one_word, clk, arst_n, (in_valid && in_ready) |=> !in_ready)
	`IIRDF1_ASSERT(a_load_shows, clk, arst_n, cmd.load_out |=> out_valid)
	`IIRDF1_NEVER(a_no_issue_idle, clk, arst_n, in_ready && cmd.issue)
	`IIRDF1_ASSERT(a_clip_rails, clk, arst_n,
		(out_valid && clipped) |-> (sample_out == OUT_MAX || sample_out == OUT_MIN))

endmodule
